// File: rtl/core/bf_pkg.sv
// Shared types and constants of the 3x3 gray box filter.
package bf_pkg;

   // Field widths of the request and result payloads
   localparam int BF_PIX_W      = 8;
   localparam int BF_ROW_W      = 12;
   localparam int BF_COL_W      = 11;
   localparam int BF_SUM_W      = 12;
   localparam int BF_CSR_DATA_W = 13;
   localparam int BF_FW_W       = 12;
   localparam int BF_FH_W       = 13;

   // Work queue between front and back
   localparam int BF_QUEUE_DEPTH = 4;
   localparam int BF_QPTR_W      = 2;
   localparam int BF_QLVL_W      = 3;

   // Divide by nine: floor(sum * 7282 / 2^16) is exact for sums below 2296
   localparam int             BF_RECIP_W     = 13;
   localparam int             BF_PROD_W      = BF_SUM_W + BF_RECIP_W;
   localparam int             BF_RECIP_SHIFT = 16;
   localparam logic [BF_RECIP_W-1:0] BF_RECIP_9 = 13'd7282;

   // Result slots that one pixel can cause, in emission order
   localparam int BF_EMIT_CENTER  = 0;
   localparam int BF_EMIT_RIGHT   = 1;
   localparam int BF_EMIT_BOTTOM  = 2;
   localparam int BF_EMIT_CORNER  = 3;
   localparam int BF_EMIT_N       = 4;

   // Configuration register indexes
   typedef enum logic [0:0] {
      BF_REG_FRAME_WIDTH  = 1'b0,
      BF_REG_FRAME_HEIGHT = 1'b1
   } bf_reg_type;

   // One classified pixel, ready to be expanded into results
   typedef struct packed {
      logic [BF_EMIT_N-1:0] emit;
      logic                 border;
      logic [BF_SUM_W-1:0]  sum;
      logic [BF_PIX_W-1:0]  p0;
      logic [BF_PIX_W-1:0]  p1;
      logic [BF_PIX_W-1:0]  wc2;
      logic [BF_PIX_W-1:0]  wc4;
      logic [BF_ROW_W-1:0]  row_m1;
      logic [BF_ROW_W-1:0]  row;
      logic [BF_COL_W-1:0]  col_m1;
      logic [BF_COL_W-1:0]  col;
   } bf_work_type;

endpackage

// File: rtl/core/bf_if.sv
// Channel interfaces of the 3x3 gray box filter: pixel requests, results, register writes.
interface bf_req_if;
   logic                           valid;
   logic                           ready;
   logic [bf_pkg::BF_PIX_W-1:0]    pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bf_pkg::BF_PIX_W-1:0]    pixel_out;
   logic [bf_pkg::BF_ROW_W-1:0]    out_row;
   logic [bf_pkg::BF_COL_W-1:0]    out_col;
   logic                           run_last;
   logic                           frame_last;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output run_last, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input run_last, input frame_last, output ready);
endinterface

interface bf_csr_if;
   logic                              valid;
   logic                              ready;
   bf_pkg::bf_reg_type                index;
   logic [bf_pkg::BF_CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/bf_front.sv
// Front end: frame counters, line stores, 3x3 window and classification of each pixel.
module bf_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   bf_req_if.sink                        req_ch,
   bf_csr_if.sink                        csr_ch,
   input  logic [bf_pkg::BF_QLVL_W-1:0]  q_level,
   output logic                          push,
   output bf_pkg::bf_work_type           push_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // Clamp a size to 3..hi and return it minus one
   function automatic logic [31:0] clamp_m1(input logic [31:0] v, input logic [31:0] hi);
      logic [31:0] res;
      if (v < 32'd3) res = 32'd2;
      else if (v > hi) res = hi - 32'd1;
      else res = v - 32'd1;
      return res;
   endfunction

   localparam logic [CW-1:0] WM1_RST = CW'(clamp_m1(32'd640, 32'(MAX_WIDTH)));
   localparam logic [RW-1:0] HM1_RST = RW'(clamp_m1(32'd480, 32'(MAX_HEIGHT)));

   logic [CW-1:0] wm1_ff, wm1_in;
   logic [RW-1:0] hm1_ff, hm1_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic                b_valid_ff, b_valid_in;
   bf_pkg::bf_work_type b_work_ff, b_work_in;
   logic [CW-1:0]       b_c_ff, b_c_in;

   logic [bf_pkg::BF_PIX_W-1:0] prev_rd_ff, prev2_rd_ff;
   logic [bf_pkg::BF_PIX_W-1:0] win_ff [6];
   logic [bf_pkg::BF_PIX_W-1:0] win_in [6];

   logic [bf_pkg::BF_PIX_W-1:0] line_prev_mem  [MAX_WIDTH];
   logic [bf_pkg::BF_PIX_W-1:0] line_prev2_mem [MAX_WIDTH];

   logic                        accept;
   logic [CW-1:0]               c;
   logic [RW-1:0]               r;
   logic                        col_end;
   logic                        row_end;
   logic [bf_pkg::BF_QLVL_W-1:0] used;
   logic [bf_pkg::BF_SUM_W-1:0] sum;

   // Reserve a queue slot for the pixel still in the window stage
   assign used         = q_level + bf_pkg::BF_QLVL_W'(b_valid_ff);
   assign req_ch.ready = used < bf_pkg::BF_QLVL_W'(bf_pkg::BF_QUEUE_DEPTH);
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Clamp the counters to the frame in use
   assign c       = (col_ff < wm1_ff) ? col_ff : wm1_ff;
   assign r       = (row_ff < hm1_ff) ? row_ff : hm1_ff;
   assign col_end = (c == wm1_ff);
   assign row_end = (r == hm1_ff);

   // Store clamped frame sizes on register writes
   always_comb begin
      wm1_in = wm1_ff;
      hm1_in = hm1_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bf_pkg::BF_REG_FRAME_WIDTH: begin
               wm1_in = CW'(clamp_m1(32'(csr_ch.data[bf_pkg::BF_FW_W-1:0]), 32'(MAX_WIDTH)));
            end
            bf_pkg::BF_REG_FRAME_HEIGHT: begin
               hm1_in = RW'(clamp_m1(32'(csr_ch.data[bf_pkg::BF_FH_W-1:0]), 32'(MAX_HEIGHT)));
            end
         endcase
      end
   end

   // Advance the raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : RW'(r + RW'(1));
         end else begin
            col_in = CW'(c + CW'(1));
            row_in = r;
         end
      end
   end

   // Classify the pixel: which results it causes and their tags
   always_comb begin
      b_valid_in = accept;
      b_c_in     = accept ? c : b_c_ff;
      b_work_in  = b_work_ff;
      if (accept) begin
         b_work_in.emit[bf_pkg::BF_EMIT_CENTER] = (r != '0) && (c != '0);
         b_work_in.emit[bf_pkg::BF_EMIT_RIGHT]  = (r != '0) && (c != '0) && col_end;
         b_work_in.emit[bf_pkg::BF_EMIT_BOTTOM] = row_end && (c != '0);
         b_work_in.emit[bf_pkg::BF_EMIT_CORNER] = row_end && col_end;
         b_work_in.border = (r == RW'(1)) || (c == CW'(1));
         b_work_in.p0     = req_ch.pixel_in;
         b_work_in.row_m1 = bf_pkg::BF_ROW_W'(RW'(r - RW'(1)));
         b_work_in.row    = bf_pkg::BF_ROW_W'(r);
         b_work_in.col_m1 = bf_pkg::BF_COL_W'(CW'(c - CW'(1)));
         b_work_in.col    = bf_pkg::BF_COL_W'(c);
      end
   end

   // Sum the nine window pixels
   always_comb begin
      sum = bf_pkg::BF_SUM_W'(b_work_ff.p0) + bf_pkg::BF_SUM_W'(prev_rd_ff)
          + bf_pkg::BF_SUM_W'(prev2_rd_ff);
      for (int i = 0; i < 6; i++) begin
         sum = sum + bf_pkg::BF_SUM_W'(win_ff[i]);
      end
   end

   // Complete the work item and shift the window
   always_comb begin
      push_data     = b_work_ff;
      push_data.sum = sum;
      push_data.p1  = prev_rd_ff;
      push_data.wc2 = win_ff[2];
      push_data.wc4 = win_ff[4];
      push          = b_valid_ff;
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i];
      end
      if (b_valid_ff) begin
         win_in[1] = win_ff[0];
         win_in[0] = prev2_rd_ff;
         win_in[3] = win_ff[2];
         win_in[2] = prev_rd_ff;
         win_in[5] = win_ff[4];
         win_in[4] = b_work_ff.p0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff     <= WM1_RST;
         hm1_ff     <= HM1_RST;
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         wm1_ff     <= wm1_in;
         hm1_ff     <= hm1_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= b_valid_in;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      b_work_ff <= b_work_in;
      b_c_ff    <= b_c_in;
   end

   // Line stores: read at the accepted column, write back in the next cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_rd_ff  <= line_prev_mem[c];
         prev2_rd_ff <= line_prev2_mem[c];
      end
      if (b_valid_ff) begin
         line_prev_mem[b_c_ff]  <= b_work_ff.p0;
         line_prev2_mem[b_c_ff] <= prev_rd_ff;
      end
   end

endmodule

// File: rtl/core/bf_queue.sv
// Work queue that decouples the front end from the result sequencer.
module bf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bf_pkg::bf_work_type           push_data,
   input  logic                          pop,
   output bf_pkg::bf_work_type           head,
   output logic                          empty,
   output logic [bf_pkg::BF_QLVL_W-1:0]  level
);

   bf_pkg::bf_work_type                 store_ff [bf_pkg::BF_QUEUE_DEPTH];
   logic [bf_pkg::BF_QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [bf_pkg::BF_QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [bf_pkg::BF_QLVL_W-1:0]        level_ff, level_in;

   assign head  = store_ff[rd_ptr_ff];
   assign empty = (level_ff == '0);
   assign level = level_ff;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? bf_pkg::BF_QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? bf_pkg::BF_QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff;
      priority if (push && !pop) begin
         level_in = bf_pkg::BF_QLVL_W'(level_ff + 1'b1);
      end else if (pop && !push) begin
         level_in = bf_pkg::BF_QLVL_W'(level_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Hold entries until overwritten
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> level_ff < bf_pkg::BF_QLVL_W'(bf_pkg::BF_QUEUE_DEPTH))
      else $error("work queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> level_ff != '0)
      else $error("work queue read while empty");
`endif

endmodule

// File: rtl/core/bf_back.sv
// Back end: expands each work item into its results and holds them in the output register.
module bf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bf_pkg::bf_work_type  head,
   input  logic                 empty,
   output logic                 pop,
   bf_rsp_if.source             rsp_ch
);

   logic [bf_pkg::BF_EMIT_N-1:0] done_ff, done_in;
   logic                         valid_ff, valid_in;
   logic [bf_pkg::BF_PIX_W-1:0]  pix_ff, pix_in;
   logic [bf_pkg::BF_ROW_W-1:0]  row_ff, row_in;
   logic [bf_pkg::BF_COL_W-1:0]  col_ff, col_in;
   logic                         run_last_ff, run_last_in;
   logic                         frame_last_ff, frame_last_in;

   logic [bf_pkg::BF_EMIT_N-1:0] pend;
   logic [bf_pkg::BF_EMIT_N-1:0] sel;
   logic [bf_pkg::BF_EMIT_N-1:0] rest;
   logic                         load_ok;
   logic                         emit_now;
   logic [bf_pkg::BF_PROD_W-1:0] prod;
   logic [bf_pkg::BF_PIX_W-1:0]  mean;
   logic [bf_pkg::BF_PIX_W-1:0]  center;

   // Results of the head item not yet sent
   assign pend     = empty ? '0 : (head.emit & ~done_ff);
   assign load_ok  = !valid_ff || rsp_ch.ready;
   assign emit_now = load_ok && (pend != '0);
   assign rest     = pend & ~sel;
   assign pop      = !empty && ((pend == '0) || (emit_now && (rest == '0)));

   // Divide the window sum by nine
   assign prod   = bf_pkg::BF_PROD_W'(head.sum) * bf_pkg::BF_PROD_W'(bf_pkg::BF_RECIP_9);
   assign mean   = prod[bf_pkg::BF_RECIP_SHIFT +: bf_pkg::BF_PIX_W];
   assign center = head.border ? head.wc2 : mean;

   // Pick the earliest pending result and its payload
   always_comb begin
      sel           = '0;
      pix_in        = pix_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      frame_last_in = frame_last_ff;
      priority if (pend[bf_pkg::BF_EMIT_CENTER]) begin
         sel[bf_pkg::BF_EMIT_CENTER] = 1'b1;
         pix_in        = center;
         row_in        = head.row_m1;
         col_in        = head.col_m1;
         frame_last_in = 1'b0;
      end else if (pend[bf_pkg::BF_EMIT_RIGHT]) begin
         sel[bf_pkg::BF_EMIT_RIGHT] = 1'b1;
         pix_in        = head.p1;
         row_in        = head.row_m1;
         col_in        = head.col;
         frame_last_in = 1'b0;
      end else if (pend[bf_pkg::BF_EMIT_BOTTOM]) begin
         sel[bf_pkg::BF_EMIT_BOTTOM] = 1'b1;
         pix_in        = head.wc4;
         row_in        = head.row;
         col_in        = head.col_m1;
         frame_last_in = 1'b0;
      end else if (pend[bf_pkg::BF_EMIT_CORNER]) begin
         sel[bf_pkg::BF_EMIT_CORNER] = 1'b1;
         pix_in        = head.p0;
         row_in        = head.row;
         col_in        = head.col;
         frame_last_in = 1'b1;
      end
   end

   // Track sent results and the output register
   always_comb begin
      done_in     = done_ff;
      valid_in    = valid_ff;
      run_last_in = run_last_ff;
      priority if (pop) begin
         done_in = '0;
      end else if (emit_now) begin
         done_in = done_ff | sel;
      end
      priority if (emit_now) begin
         valid_in    = 1'b1;
         run_last_in = (rest == '0);
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (emit_now) begin
         pix_ff        <= pix_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         run_last_ff   <= run_last_in;
         frame_last_ff <= frame_last_in;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.pixel_out  = pix_ff;
   assign rsp_ch.out_row    = row_ff;
   assign rsp_ch.out_col    = col_ff;
   assign rsp_ch.run_last   = run_last_ff;
   assign rsp_ch.frame_last = frame_last_ff;

`ifndef SYNTH
   a_frame_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_last |-> rsp_ch.run_last)
      else $error("frame end result not marked as last of its request");

   a_one_result_per_load: assert property (@(posedge clock) disable iff (reset)
      emit_now |-> $onehot(sel))
      else $error("result slot selection not one-hot");
`endif

endmodule

// File: rtl/core/box_filter_3x3_gray.sv
// Top level of the 3x3 gray box filter: front end, work queue and result sequencer.
// Gray pixels arrive in raster order, one request per clock; each interior pixel comes out as
// the truncated mean of its 3x3 neighborhood and border pixels pass through, tagged with row
// and column. A request is taken in every cycle while the four-entry work queue has room; the
// result side sends one result per cycle from a registered output while the receiver is ready,
// so pixels of the last row, most of which cause two results each, hold back the request side
// once the queue fills. On its way to its first result on the result port, a pixel passes the
// line store read and window stage registers, a work queue entry and the output register, in
// that order. The line stores are single-port-write memories of MAX_WIDTH bytes with no clearing
// pass after reset; frame sizes must be written through the register channel only while no
// pixel is in flight, and the block itself does not enforce this.
module box_filter_3x3_gray #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic       clock,
   input  logic       reset,
   bf_req_if.sink     req_ch,
   bf_rsp_if.source   rsp_ch,
   bf_csr_if.sink     csr_ch
);

   logic                          push;
   bf_pkg::bf_work_type           push_data;
   logic                          pop;
   bf_pkg::bf_work_type           head;
   logic                          empty;
   logic [bf_pkg::BF_QLVL_W-1:0]  q_level;

   bf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .q_level   (q_level),
      .push      (push),
      .push_data (push_data)
   );

   bf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .level     (q_level)
   );

   bf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
